// ===== hw/rtl/itda_pkg.sv =====
`default_nettype none

package itda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_digit;
        logic emit_sign;
    } itda_cmd_t;

    typedef struct packed {
        logic neg_in;
        logic digit_zero;
        logic pos_zero;
    } itda_stat_t;

    // decimal digits needed for the largest unsigned w-bit value
    function automatic int dec_digits(input int w);
        logic [63:0] v;
        int          n;
        v = (~64'd0) >> (64 - w);
        n = 0;
        while (v != 64'd0)
        begin
            v = v / 64'd10;
            n++;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itda_dp.sv =====
`default_nettype none

module itda_dp #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic [WORD_WIDTH-1:0]  value,
    input  wire logic                   opcode,
    input  wire itda_pkg::itda_cmd_t    cmd,
    output itda_pkg::itda_stat_t        stat,
    output logic [7:0]                  char_code,
    output logic                        is_last
);
    import itda_pkg::*;

    localparam int NDIG = dec_digits(WORD_WIDTH);
    localparam int PW   = $clog2(NDIG);
    localparam int MW   = WORD_WIDTH + 4;

    // d * 10^k for k = 0..NDIG-1, d = 1..9
    function automatic logic [NDIG*9*MW-1:0] build_mult();
        logic [NDIG*9*MW-1:0] t;
        logic [MW-1:0]        p;
        t = '0;
        p = MW'(1);
        for (int k = 0; k < NDIG; k++)
        begin
            for (int d = 1; d <= 9; d++)
            begin
                t[(k*9+d-1)*MW +: MW] = p * MW'(d);
            end
            p = p * MW'(10);
        end
        return t;
    endfunction

    localparam logic [NDIG*9*MW-1:0] MULT_FLAT = build_mult();

    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic [WORD_WIDTH-1:0] mag;
    logic [3:0]            digit;
    logic [MW-1:0]         sub;
    logic [MW-1:0]         mult_d;

    assign stat.neg_in     = !opcode && value[WORD_WIDTH-1];
    assign mag             = stat.neg_in ? (~value + WORD_WIDTH'(1)) : value;
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.digit_zero = (digit == 4'd0);

    always_comb
    begin
        int idx;
        digit = 4'd0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            idx    = int'(pos_reg) * 9 + d - 1;
            mult_d = MULT_FLAT[idx*MW +: MW];
            if ({4'b0, rem_reg} >= mult_d)
            begin
                digit = 4'(d);
                sub   = mult_d;
            end
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            rem_next = mag;
            pos_next = PW'(NDIG - 1);
        end
        else if (cmd.step)
        begin
            rem_next = rem_reg - sub[WORD_WIDTH-1:0];
            pos_next = pos_reg - PW'(1);
        end
        if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_next = CHAR_ZERO + {4'b0, digit};
            last_next = stat.pos_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_code = char_reg;
    assign is_last   = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/itda_ctrl.sv =====
`default_nettype none

module itda_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire itda_pkg::itda_stat_t stat,
    output itda_pkg::itda_cmd_t       cmd
);
    import itda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   emit_now;

    assign out_free = !out_valid_reg || out_ready;
    assign emit_now = started_reg || !stat.digit_zero || stat.pos_zero;

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    started_next = 1'b0;
                    state_next   = stat.neg_in ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (!emit_now)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.step       = 1'b1;
                    cmd.emit_digit = 1'b1;
                    started_next   = 1'b1;
                    if (stat.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/int_to_decimal_ascii_top.sv =====
// Integer to decimal ASCII converter.
// Slave stream: one beat per number; tdata carries the word, tuser selects
// the reading (0 = signed two's complement, 1 = unsigned).
// Master stream: one beat per character, most significant first, with a
// leading '-' for negative signed values; tlast marks the final character.
// Digits come from a fixed table of d * 10^k, one decimal position per cycle
// unless a digit waits on a stalled receiver, with leading zeros skipped silently.
// Sequence: a load step, then a sign step for negative values, then one
// step per decimal position of the widest word (10 for 32 bits). Leading
// zeros are stepped over without output, so the first character comes
// later when they are present. The next number is taken only once the last
// character is in the output register. A stalled receiver holds the output
// register and freezes the conversion at the next sign or digit to emit
// until the character is taken; leading zeros are still skipped meanwhile.
// Reset clears the controller and drops m_tvalid; no clearing pass needed.
`default_nettype none

module int_to_decimal_ascii_top #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((WORD_WIDTH+7)/8)*8-1:0]     s_tdata,  // value
    input  wire logic                                s_tuser,  // opcode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,  // char_code
    output logic                                     m_tlast   // is_last
);
    import itda_pkg::*;

    itda_cmd_t  cmd;
    itda_stat_t stat;

    itda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    itda_dp #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .value     (s_tdata[WORD_WIDTH-1:0]),
        .opcode    (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .char_code (m_tdata),
        .is_last   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/int_to_decimal_ascii_top_test.sv =====
`timescale 1ns / 1ps

module int_to_decimal_ascii_top_test;

    import itda_pkg::*;

    localparam int WORD_WIDTH = 32;
    localparam int DATA_W = ((WORD_WIDTH + 7) / 8) * 8;
    localparam logic OP_SIGNED = 1'b0;
    localparam logic OP_UNSIGNED = 1'b1;
    localparam int MAX_IDLE = 8;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // value
    logic              s_tuser;   // opcode
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // char_code
    logic              m_tlast;   // is_last

    logic       send_gaps;
    logic       recv_gaps;
    int         mismatch_count;
    char_beat_t expected_chars[$];

    int_to_decimal_ascii_top #(
        .WORD_WIDTH(WORD_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("int_to_decimal_ascii_top verification failed");
        $finish;
    end

    function automatic int draw_idle(input logic enable);
        return enable ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    // expected text of one number, one beat per character
    function automatic void predict_text(input logic [DATA_W-1:0] raw, input logic op);
        logic [WORD_WIDTH-1:0] mag;
        logic                  neg;
        logic [3:0]            digits [12];
        int                    n;
        int                    i;
        char_beat_t            beat;
        mag = raw[WORD_WIDTH-1:0];
        neg = (op == OP_SIGNED) && mag[WORD_WIDTH-1];
        if (neg)
            mag = ~mag + 1'b1;
        n = 0;
        do
        begin
            digits[n] = 4'(mag % 10);
            n++;
            mag = mag / 10;
        end
        while (mag != 0);
        if (neg)
        begin
            beat.code = CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (i = n - 1; i >= 0; i--)
        begin
            beat.code = CHAR_ZERO + 8'(digits[i]);
            beat.last = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic send_number(input logic [DATA_W-1:0] v, input logic op);
        int gap;
        gap = draw_idle(send_gaps);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_text(v, op);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] p;
        int                k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2:
            begin
                k = $urandom_range(0, 9);
                p = 1;
                repeat (k) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            3: v = -$urandom_range(0, 1000);
            4: v = $urandom_range(0, 99);
            default:
            begin
                if ($urandom_range(0, 1))
                    v = 32'h8000_0000 + $urandom_range(0, 3);
                else
                    v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
        endcase
        return v;
    endfunction

    task automatic test_directed_extremes();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_number(32'd0, OP_SIGNED);
        send_number(32'd0, OP_UNSIGNED);
        send_number(32'd1, OP_SIGNED);
        send_number(32'd9, OP_UNSIGNED);
        send_number(32'd10, OP_SIGNED);
        send_number(32'd99, OP_UNSIGNED);
        send_number(32'd100, OP_SIGNED);
        send_number(32'h7FFF_FFFF, OP_SIGNED);
        send_number(32'h7FFF_FFFF, OP_UNSIGNED);
        send_number(32'h8000_0000, OP_SIGNED);
        send_number(32'h8000_0000, OP_UNSIGNED);
        send_number(32'hFFFF_FFFF, OP_SIGNED);
        send_number(32'hFFFF_FFFF, OP_UNSIGNED);
        send_number(32'hFFFF_FFFE, OP_SIGNED);
        send_number(32'hFFFF_FFF6, OP_SIGNED);
        send_number(32'd999_999_999, OP_SIGNED);
        send_number(32'd1_000_000_000, OP_SIGNED);
        send_number(32'd1_000_000_000, OP_UNSIGNED);
        send_number(32'd4_000_000_000, OP_UNSIGNED);
        send_number(32'd4_000_000_000, OP_SIGNED);
        send_number(32'h5555_5555, OP_SIGNED);
        send_number(32'hAAAA_AAAA, OP_SIGNED);
        send_number(32'hAAAA_AAAA, OP_UNSIGNED);
    endtask

    task automatic test_random_lengths();
        int i;
        for (i = 0; i < 200; i++)
        begin
            if (i % 25 == 0)
            begin
                send_gaps = 1'($urandom_range(0, 1));
                recv_gaps = 1'($urandom_range(0, 1));
            end
            send_number(random_value(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_back_to_back();
        int i;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        for (i = 0; i < 80; i++)
            send_number(random_value(), 1'($urandom_range(0, 1)));
    endtask

    // receiver: random stall before each beat when recv_gaps is set
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int gap;
            gap = draw_idle(recv_gaps);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: char 0x%02h last %0b", m_tdata, m_tlast);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.code || m_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                                 want.code, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    initial
    begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_SIGNED;
        rst_n          = 1'b0;
        send_gaps      = 1'b0;
        recv_gaps      = 1'b0;
        mismatch_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_random_lengths();
        test_back_to_back();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("int_to_decimal_ascii_top verification clean");
        else
            $display("int_to_decimal_ascii_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/itda_pkg.sv
hw/rtl/itda_dp.sv
hw/rtl/itda_ctrl.sv
hw/rtl/int_to_decimal_ascii_top.sv
tb/int_to_decimal_ascii_top_test.sv
